/* rtl/hbe_pkg.sv */
// Shared types, byte codes and the decimal digit helper for the half-block encoder.
// No dependencies; used by every module of the block.
package hbe_pkg;

	localparam logic [1:0] KIND_CELL  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LB    = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] GLYPH0   = 8'hE2;
	localparam logic [7:0] GLYPH1   = 8'h96;
	localparam logic [7:0] GLYPH2   = 8'h80;

	localparam int QDEPTH = 4;

	// one request from the front to the byte sequencer
	typedef struct packed {
		logic        is_end;
		logic        pos;
		logic        adv;
		logic [6:0]  row;
		logic [7:0]  col;
		logic [7:0]  skip;
		logic        fch;
		logic        bch;
		logic        eq;
		logic        tc;
		logic [23:0] top;
		logic [23:0] bot;
	} cmd_t;

	typedef struct packed {
		logic [3:0] h;
		logic [3:0] t;
		logic [3:0] o;
		logic [1:0] cnt;
	} dec_t;

	// split a value below 300 into digits; tens by reciprocal multiply
	function automatic dec_t dec3(input logic [8:0] v);
		dec_t       d;
		logic [8:0] r;
		logic [14:0] p;
		logic [6:0] r7;
		logic [6:0] o7;
		d.h = (v >= 9'd200) ? 4'd2 : ((v >= 9'd100) ? 4'd1 : 4'd0);
		r = v - 9'(d.h) * 9'd100;
		r7 = r[6:0];
		p = 15'(r7) * 15'd205;
		d.t = p[14:11];
		o7 = r7 - 7'(d.t) * 7'd10;
		d.o = o7[3:0];
		d.cnt = (d.h != 4'd0) ? 2'd3 : ((d.t != 4'd0) ? 2'd2 : 2'd1);
		return d;
	endfunction

endpackage

/* rtl/hbe_cmd_queue.sv */
// Short request queue between the front classifier and the byte sequencer.
// Depends on hbe_pkg for the request type and depth.
module hbe_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hbe_pkg::cmd_t din,
	output logic          full,
	input  logic          pop,
	output hbe_pkg::cmd_t dout,
	output logic          empty
);
	import hbe_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	cmd_t          slot_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) slot_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end
endmodule

/* rtl/hbe_front.sv */
// Front part: accepts items, looks up the previous frame store, tracks colors and
// cursor state, and issues byte requests. Depends on hbe_pkg.
module hbe_front #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          truecolor_mode,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    kind,
	input  logic          redraw_all,
	input  logic [23:0]   top_value,
	input  logic [23:0]   bottom_value,
	input  logic [6:0]    cell_row,
	input  logic [7:0]    cell_col,
	output hbe_pkg::cmd_t cmd,
	output logic          cmd_push,
	input  logic          cmd_full
);
	import hbe_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [47:0]   mem [DEPTH];

	logic          clr_q;
	logic [AW-1:0] clr_addr_q;

	logic          acc;
	logic          in_oob;
	logic [AW-1:0] in_idx;
	logic [23:0]   cmask;

	logic          valid_s1;
	logic [1:0]    kind_s1;
	logic          redraw_s1;
	logic [23:0]   top_s1;
	logic [23:0]   bot_s1;
	logic [6:0]    row_s1;
	logic [7:0]    col_s1;
	logic          oob_s1;
	logic [AW-1:0] idx_s1;
	logic [47:0]   rd_s1;

	logic          fwd_v_q;
	logic [AW-1:0] fwd_idx_q;
	logic [47:0]   fwd_word_q;

	logic [23:0]   fg_q, bg_q;
	logic          fgv_q, bgv_q, full_frame_q, ls_q;
	logic [6:0]    line_q;
	logic [7:0]    skip_q;

	logic [23:0]   fg_d, bg_d;
	logic          fgv_d, bgv_d, full_frame_d, ls_d;
	logic [6:0]    line_d;
	logic [7:0]    skip_d;

	logic [47:0]   word;
	logic [47:0]   prev;
	logic          draw;
	logic          need_push;
	logic          go;
	logic          we;
	logic [AW-1:0] wa;
	logic [47:0]   wd;

	assign cmask  = truecolor_mode ? 24'hFFFFFF : 24'h0000FF;
	assign in_oob = (32'(cell_row) >= 32'(MAX_ROWS)) || (32'(cell_col) >= 32'(MAX_COLS));
	assign in_idx = in_oob ? '0 : AW'(32'(cell_row) * 32'(MAX_COLS) + 32'(cell_col));

	assign go   = valid_s1 && (!need_push || !cmd_full);
	assign full = clr_q || (valid_s1 && !go);
	assign acc  = push && !full;

	assign word = {bot_s1, top_s1};
	assign prev = (fwd_v_q && fwd_idx_q == idx_s1) ? fwd_word_q : rd_s1;

	always_comb begin
		fg_d         = fg_q;
		bg_d         = bg_q;
		fgv_d        = fgv_q;
		bgv_d        = bgv_q;
		full_frame_d = full_frame_q;
		ls_d         = ls_q;
		line_d       = line_q;
		skip_d       = skip_q;
		draw         = 1'b0;
		need_push    = 1'b0;
		cmd          = '0;
		cmd.row      = row_s1;
		cmd.col      = col_s1;
		cmd.top      = top_s1;
		cmd.bot      = bot_s1;
		cmd.tc       = truecolor_mode;
		cmd.eq       = (top_s1 == bot_s1);
		case (kind_s1)
			KIND_START: begin
				full_frame_d = full_frame_q | redraw_s1;
				fgv_d  = 1'b0;
				bgv_d  = 1'b0;
				ls_d   = 1'b0;
				skip_d = '0;
			end
			KIND_END: begin
				need_push    = 1'b1;
				cmd.is_end   = 1'b1;
				full_frame_d = 1'b0;
				fgv_d  = 1'b0;
				bgv_d  = 1'b0;
				ls_d   = 1'b0;
				skip_d = '0;
			end
			KIND_CELL: begin
				if (!oob_s1) begin
					if (row_s1 != line_q) begin
						ls_d   = 1'b0;
						skip_d = '0;
						line_d = row_s1;
					end
					if (full_frame_q || prev != word) begin
						draw    = 1'b1;
						cmd.pos = !ls_d;
						cmd.adv = ls_d && skip_d != 8'd0;
						cmd.skip = skip_d;
						ls_d    = 1'b1;
						skip_d  = '0;
					end else if (ls_d) begin
						if (skip_d == 8'd255) begin
							ls_d   = 1'b0;
							skip_d = '0;
						end else begin
							skip_d = skip_d + 8'd1;
						end
					end
					if (draw) begin
						need_push = 1'b1;
						cmd.bch = !bgv_q || bot_s1 != bg_q;
						cmd.fch = !cmd.eq && (!fgv_q || top_s1 != fg_q);
						if (cmd.bch) begin
							bg_d  = bot_s1;
							bgv_d = 1'b1;
						end
						if (cmd.fch) begin
							fg_d  = top_s1;
							fgv_d = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd_push = go && need_push;
	assign we = clr_q || (go && draw);
	assign wa = clr_q ? clr_addr_q : idx_s1;
	assign wd = clr_q ? '0 : word;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (acc) rd_s1 <= mem[in_idx];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1   <= kind;
			redraw_s1 <= redraw_all;
			top_s1    <= top_value & cmask;
			bot_s1    <= bottom_value & cmask;
			row_s1    <= cell_row;
			col_s1    <= cell_col;
			oob_s1    <= in_oob;
			idx_s1    <= in_idx;
			fwd_idx_q  <= idx_s1;
			fwd_word_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= 1'b1;
			clr_addr_q   <= '0;
			valid_s1     <= 1'b0;
			fwd_v_q      <= 1'b0;
			fg_q         <= '0;
			bg_q         <= '0;
			fgv_q        <= 1'b0;
			bgv_q        <= 1'b0;
			full_frame_q <= 1'b1;
			ls_q         <= 1'b0;
			line_q       <= '0;
			skip_q       <= '0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
			end
			if (acc) fwd_v_q <= go && draw;
			if (acc) valid_s1 <= 1'b1;
			else if (go) valid_s1 <= 1'b0;
			if (go) begin
				fg_q         <= fg_d;
				bg_q         <= bg_d;
				fgv_q        <= fgv_d;
				bgv_q        <= bgv_d;
				full_frame_q <= full_frame_d;
				ls_q         <= ls_d;
				line_q       <= line_d;
				skip_q       <= skip_d;
			end
		end
	end
endmodule

/* rtl/hbe_back.sv */
// Back part: walks one request through its escape sequences into the output register,
// one byte per cycle while the waiting byte is popped. Depends on hbe_pkg.
module hbe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  hbe_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic [7:0]    out_byte,
	output logic          last,
	output logic          empty,
	input  logic          pop
);
	import hbe_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_E_ESC = 5'd1;
	localparam logic [4:0] S_E_LB  = 5'd2;
	localparam logic [4:0] S_E_0   = 5'd3;
	localparam logic [4:0] S_E_M   = 5'd4;
	localparam logic [4:0] S_P_ESC = 5'd5;
	localparam logic [4:0] S_P_LB  = 5'd6;
	localparam logic [4:0] S_P_SEM = 5'd7;
	localparam logic [4:0] S_P_H   = 5'd8;
	localparam logic [4:0] S_A_ESC = 5'd9;
	localparam logic [4:0] S_A_LB  = 5'd10;
	localparam logic [4:0] S_A_C   = 5'd11;
	localparam logic [4:0] S_G_ESC = 5'd12;
	localparam logic [4:0] S_G_LB  = 5'd13;
	localparam logic [4:0] S_G_SEP = 5'd14;
	localparam logic [4:0] S_G_M   = 5'd15;
	localparam logic [4:0] S_C_LD  = 5'd16;
	localparam logic [4:0] S_C_8   = 5'd17;
	localparam logic [4:0] S_C_S1  = 5'd18;
	localparam logic [4:0] S_C_MD  = 5'd19;
	localparam logic [4:0] S_C_S2  = 5'd20;
	localparam logic [4:0] S_C_S3  = 5'd21;
	localparam logic [4:0] S_C_S4  = 5'd22;
	localparam logic [4:0] S_SP    = 5'd23;
	localparam logic [4:0] S_B0    = 5'd24;
	localparam logic [4:0] S_B1    = 5'd25;
	localparam logic [4:0] S_B2    = 5'd26;
	localparam logic [4:0] S_NUM   = 5'd27;

	cmd_t       cur_q;
	logic [4:0] st_q, ret_q;
	logic       wbg_q;
	dec_t       dig_q;
	logic       oval_q;
	logic [7:0] obyte_q;
	logic       olast_q;

	logic       adv;
	logic [4:0] st_d, ret_d, glyph_st, after_pfx, after_col;
	logic       wbg_d;
	logic       emit;
	logic [7:0] byte_c;
	logic       num_ld;
	logic [8:0] num_v;
	logic [23:0] colv;
	dec_t       dec_c;
	logic [3:0] dsel;

	assign adv   = !oval_q || pop;
	assign empty = !oval_q;
	assign out_byte = obyte_q;
	assign last  = olast_q;

	assign colv      = wbg_q ? cur_q.bot : cur_q.top;
	assign glyph_st  = cur_q.eq ? S_SP : S_B0;
	assign after_pfx = (cur_q.fch || cur_q.bch) ? S_G_ESC : glyph_st;
	assign after_col = (!wbg_q && cur_q.bch) ? S_G_SEP : S_G_M;
	assign dec_c     = dec3(num_v);
	assign dsel      = (dig_q.cnt == 2'd3) ? dig_q.h : ((dig_q.cnt == 2'd2) ? dig_q.t : dig_q.o);
	assign cmd_pop   = adv && (st_q == S_IDLE) && !cmd_empty;

	always_comb begin
		st_d   = st_q;
		ret_d  = ret_q;
		wbg_d  = wbg_q;
		emit   = 1'b1;
		byte_c = CH_ESC;
		num_ld = 1'b0;
		num_v  = '0;
		case (st_q)
			S_IDLE: begin
				emit = 1'b0;
				if (!cmd_empty) begin
					if (cmd.is_end) st_d = S_E_ESC;
					else if (cmd.pos) st_d = S_P_ESC;
					else if (cmd.adv) st_d = S_A_ESC;
					else if (cmd.fch || cmd.bch) st_d = S_G_ESC;
					else st_d = cmd.eq ? S_SP : S_B0;
				end
			end
			S_E_ESC: st_d = S_E_LB;
			S_E_LB: begin
				byte_c = CH_LB;
				st_d = S_E_0;
			end
			S_E_0: begin
				byte_c = CH_ZERO;
				st_d = S_E_M;
			end
			S_E_M: begin
				byte_c = CH_M;
				st_d = S_IDLE;
			end
			S_P_ESC: st_d = S_P_LB;
			S_P_LB: begin
				byte_c = CH_LB;
				num_ld = 1'b1;
				num_v  = 9'(cur_q.row) + 9'd1;
				st_d   = S_NUM;
				ret_d  = S_P_SEM;
			end
			S_P_SEM: begin
				byte_c = CH_SEMI;
				num_ld = 1'b1;
				num_v  = 9'(cur_q.col) + 9'd1;
				st_d   = S_NUM;
				ret_d  = S_P_H;
			end
			S_P_H: begin
				byte_c = CH_H;
				st_d = after_pfx;
			end
			S_A_ESC: st_d = S_A_LB;
			S_A_LB: begin
				byte_c = CH_LB;
				if (cur_q.skip != 8'd1) begin
					num_ld = 1'b1;
					num_v  = 9'(cur_q.skip);
					st_d   = S_NUM;
					ret_d  = S_A_C;
				end else begin
					st_d = S_A_C;
				end
			end
			S_A_C: begin
				byte_c = CH_C;
				st_d = after_pfx;
			end
			S_G_ESC: st_d = S_G_LB;
			S_G_LB: begin
				byte_c = CH_LB;
				wbg_d = !cur_q.fch;
				st_d = S_C_LD;
			end
			S_G_SEP: begin
				byte_c = CH_SEMI;
				wbg_d = 1'b1;
				st_d = S_C_LD;
			end
			S_G_M: begin
				byte_c = CH_M;
				st_d = glyph_st;
			end
			S_C_LD: begin
				byte_c = wbg_q ? CH_FOUR : CH_THREE;
				st_d = S_C_8;
			end
			S_C_8: begin
				byte_c = CH_EIGHT;
				st_d = S_C_S1;
			end
			S_C_S1: begin
				byte_c = CH_SEMI;
				st_d = S_C_MD;
			end
			S_C_MD: begin
				byte_c = cur_q.tc ? CH_TWO : CH_FIVE;
				st_d = S_C_S2;
			end
			S_C_S2: begin
				byte_c = CH_SEMI;
				num_ld = 1'b1;
				num_v  = 9'(colv[7:0]);
				st_d   = S_NUM;
				ret_d  = cur_q.tc ? S_C_S3 : after_col;
			end
			S_C_S3: begin
				byte_c = CH_SEMI;
				num_ld = 1'b1;
				num_v  = 9'(colv[15:8]);
				st_d   = S_NUM;
				ret_d  = S_C_S4;
			end
			S_C_S4: begin
				byte_c = CH_SEMI;
				num_ld = 1'b1;
				num_v  = 9'(colv[23:16]);
				st_d   = S_NUM;
				ret_d  = after_col;
			end
			S_SP: begin
				byte_c = CH_SPACE;
				st_d = S_IDLE;
			end
			S_B0: begin
				byte_c = GLYPH0;
				st_d = S_B1;
			end
			S_B1: begin
				byte_c = GLYPH1;
				st_d = S_B2;
			end
			S_B2: begin
				byte_c = GLYPH2;
				st_d = S_IDLE;
			end
			S_NUM: begin
				byte_c = CH_ZERO + 8'(dsel);
				if (dig_q.cnt == 2'd1) st_d = ret_q;
			end
			default: begin
				emit = 1'b0;
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (cmd_pop) cur_q <= cmd;
			if (emit) begin
				obyte_q <= byte_c;
				olast_q <= (st_q == S_E_M) || (st_q == S_SP) || (st_q == S_B2);
			end
			if (num_ld) dig_q <= dec_c;
			else if (st_q == S_NUM) dig_q.cnt <= dig_q.cnt - 2'd1;
			ret_q <= ret_d;
			wbg_q <= wbg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			oval_q <= 1'b0;
		end else if (adv) begin
			st_q   <= st_d;
			oval_q <= emit;
		end
	end
endmodule

/* rtl/half_block_ansi_cell_encoder.sv */
// Top level of the half-block ANSI cell encoder: front classifier, request queue
// and byte sequencer. Depends on hbe_pkg, hbe_front, hbe_cmd_queue and hbe_back.
// Flow: a taken item is registered in the front, queued and sequenced into bytes, one byte
//   a cycle while popped. The front takes one item a cycle while full is low; the
//   sequencer takes a new request only after the last byte of the one before.
// Reset: arst_n clears control state, then a clearing pass writes zeros through all
//   MAX_ROWS*MAX_COLS entries of the previous-frame store with full held high;
//   truecolor_mode resets to 1.
module half_block_ansi_cell_encoder #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  kind,
	input  logic        redraw_all,
	input  logic [23:0] top_value,
	input  logic [23:0] bottom_value,
	input  logic [6:0]  cell_row,
	input  logic [7:0]  cell_col,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last
);
	import hbe_pkg::*;

	logic truecolor_q;
	cmd_t f_cmd, q_cmd;
	logic f_push, q_full, q_pop, q_empty;

	// hold the color form; the user must write it only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) truecolor_q <= 1'b1;
		else if (cfg_we) truecolor_q <= cfg_wdata;
	end

	// front: store lookup, change detection, color and cursor tracking
	hbe_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.truecolor_mode(truecolor_q),
		.push(push),
		.full(full),
		.kind(kind),
		.redraw_all(redraw_all),
		.top_value(top_value),
		.bottom_value(bottom_value),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cmd(f_cmd),
		.cmd_push(f_push),
		.cmd_full(q_full)
	);

	// queue: lets the front run ahead while bytes drain
	hbe_cmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_push),
		.din(f_cmd),
		.full(q_full),
		.pop(q_pop),
		.dout(q_cmd),
		.empty(q_empty)
	);

	// back: expand each request into escape bytes
	hbe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(q_empty),
		.cmd(q_cmd),
		.cmd_pop(q_pop),
		.out_byte(out_byte),
		.last(last),
		.empty(empty),
		.pop(pop)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> !q_full)
		else $error("request pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("sequencer took a request from an empty queue");

	a_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last)))
		else $error("waiting byte changed before it was taken");
endmodule

/* dv/half_block_ansi_cell_encoder_test.sv */
// Self-checking test of half_block_ansi_cell_encoder: drives cell and frame requests,
// predicts the terminal byte stream in-bench and checks every popped byte.
// Depends on hbe_pkg (request kind codes, byte codes) and the encoder RTL.
`timescale 1ns / 1ps

module half_block_ansi_cell_encoder_test;
	import hbe_pkg::*;

	localparam int COLS = 256;
	localparam int STALL_PCT = 17;
	// the clearing pass after reset holds full high and counts toward this limit
	localparam int WATCHDOG_LIMIT = 200000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
	} term_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        push;
	logic        full;
	logic [1:0]  kind;
	logic        redraw_all;
	logic [23:0] top_value;
	logic [23:0] bottom_value;
	logic [6:0]  cell_row;
	logic [7:0]  cell_col;
	logic        empty;
	logic        pop;
	logic [7:0]  out_byte;
	logic        last;

	half_block_ansi_cell_encoder uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .kind(kind), .redraw_all(redraw_all),
		.top_value(top_value), .bottom_value(bottom_value),
		.cell_row(cell_row), .cell_col(cell_col),
		.empty(empty), .pop(pop), .out_byte(out_byte), .last(last)
	);

	// terminal-state shadow of the encoder
	logic        truecolor;
	logic [23:0] term_fg, term_bg;
	logic        term_fg_set, term_bg_set;
	logic        repaint_all;
	logic        row_open;
	logic [6:0]  row_now;
	logic [7:0]  skip_run;
	logic [47:0] screen_shadow [int];

	term_byte_t  expected_bytes[$];
	logic [7:0]  pending_bytes[$];
	int          errors;
	int          quiet_cycles;
	bit          steady;	// hold both sides free of gaps

	always begin
		#4 clk = 1'b0;
		#4 clk = 1'b1;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void emit_dec(input int unsigned v);
		int unsigned div;
		bit started;
		started = 0;
		for (div = 100; div >= 1; div = div / 10) begin
			if (started || (v / div) % 10 != 0 || div == 1) begin
				pending_bytes.push_back(CH_ZERO + 8'((v / div) % 10));
				started = 1;
			end
			if (div == 1)
				break;
		end
	endfunction

	function automatic void emit_colour(input logic [7:0] lead, input logic [23:0] v);
		pending_bytes.push_back(lead);
		pending_bytes.push_back(CH_EIGHT);
		pending_bytes.push_back(CH_SEMI);
		if (truecolor) begin
			pending_bytes.push_back(CH_TWO);
			pending_bytes.push_back(CH_SEMI);
			emit_dec(v[7:0]);
			pending_bytes.push_back(CH_SEMI);
			emit_dec(v[15:8]);
			pending_bytes.push_back(CH_SEMI);
			emit_dec(v[23:16]);
		end else begin
			pending_bytes.push_back(CH_FIVE);
			pending_bytes.push_back(CH_SEMI);
			emit_dec(v[7:0]);
		end
	endfunction

	function automatic void emit_cursor_move(input logic [6:0] row, input logic [7:0] col);
		pending_bytes.push_back(CH_ESC);
		pending_bytes.push_back(CH_LB);
		emit_dec(row + 1);
		pending_bytes.push_back(CH_SEMI);
		emit_dec(col + 1);
		pending_bytes.push_back(CH_H);
	endfunction

	function automatic void emit_glyph(input logic [23:0] top, input logic [23:0] bot);
		bit fch, bch;
		if (top == bot) begin
			if (!term_bg_set || bot != term_bg) begin
				pending_bytes.push_back(CH_ESC);
				pending_bytes.push_back(CH_LB);
				emit_colour(CH_FOUR, bot);
				pending_bytes.push_back(CH_M);
				term_bg = bot;
				term_bg_set = 1'b1;
			end
			pending_bytes.push_back(CH_SPACE);
		end else begin
			fch = !term_fg_set || top != term_fg;
			bch = !term_bg_set || bot != term_bg;
			if (fch || bch) begin
				pending_bytes.push_back(CH_ESC);
				pending_bytes.push_back(CH_LB);
				if (fch) begin
					emit_colour(CH_THREE, top);
					term_fg = top;
					term_fg_set = 1'b1;
					if (bch)
						pending_bytes.push_back(CH_SEMI);
				end
				if (bch) begin
					emit_colour(CH_FOUR, bot);
					term_bg = bot;
					term_bg_set = 1'b1;
				end
				pending_bytes.push_back(CH_M);
			end
			pending_bytes.push_back(GLYPH0);
			pending_bytes.push_back(GLYPH1);
			pending_bytes.push_back(GLYPH2);
		end
	endfunction

	function automatic logic [47:0] stored_cell(input int idx);
		return screen_shadow.exists(idx) ? screen_shadow[idx] : 48'd0;
	endfunction

	function automatic void encode_cell(input logic [23:0] top_in, input logic [23:0] bot_in,
			input logic [6:0] row, input logic [7:0] col);
		logic [23:0] top, bot;
		logic [47:0] word;
		int idx;
		top = truecolor ? top_in : {16'd0, top_in[7:0]};
		bot = truecolor ? bot_in : {16'd0, bot_in[7:0]};
		idx = int'(row) * COLS + int'(col);
		word = {bot, top};
		if (row != row_now) begin
			row_open = 1'b0;
			skip_run = 8'd0;
			row_now = row;
		end
		if (repaint_all) begin
			if (!row_open) begin
				emit_cursor_move(row, col);
				row_open = 1'b1;
			end
			emit_glyph(top, bot);
			screen_shadow[idx] = word;
		end else if (stored_cell(idx) != word) begin
			if (!row_open) begin
				emit_cursor_move(row, col);
				row_open = 1'b1;
			end else if (skip_run != 8'd0) begin
				pending_bytes.push_back(CH_ESC);
				pending_bytes.push_back(CH_LB);
				if (skip_run != 8'd1)
					emit_dec(skip_run);
				pending_bytes.push_back(CH_C);
			end
			skip_run = 8'd0;
			emit_glyph(top, bot);
			screen_shadow[idx] = word;
		end else if (row_open) begin
			// a full skip counter forces an absolute move at the next change
			if (skip_run == 8'd255) begin
				row_open = 1'b0;
				skip_run = 8'd0;
			end else begin
				skip_run++;
			end
		end
	endfunction

	// work out the bytes one accepted request causes and queue them
	function automatic void encode_request(input logic [1:0] k, input logic redraw,
			input logic [23:0] top, input logic [23:0] bot,
			input logic [6:0] row, input logic [7:0] col);
		int n;
		pending_bytes.delete();
		case (k)
			KIND_CELL: encode_cell(top, bot, row, col);
			KIND_START: begin
				if (redraw)
					repaint_all = 1'b1;
				term_fg_set = 1'b0;
				term_bg_set = 1'b0;
				row_open = 1'b0;
				skip_run = 8'd0;
			end
			KIND_END: begin
				pending_bytes.push_back(CH_ESC);
				pending_bytes.push_back(CH_LB);
				pending_bytes.push_back(CH_ZERO);
				pending_bytes.push_back(CH_M);
				repaint_all = 1'b0;
				term_fg_set = 1'b0;
				term_bg_set = 1'b0;
				row_open = 1'b0;
				skip_run = 8'd0;
			end
			default: ;	// unused kind: drop
		endcase
		n = (pending_bytes.size() > 49) ? 49 : pending_bytes.size();
		for (int i = 0; i < n; i++)
			expected_bytes.push_back('{code: pending_bytes[i], fin: (i == n - 1)});
	endfunction

	// ---------------------------------------------------------------- stimulus

	// hold push through a request until the encoder takes it, then predict
	task automatic send_request(input logic [1:0] k, input logic redraw,
			input logic [23:0] top, input logic [23:0] bot,
			input logic [6:0] row, input logic [7:0] col);
		if (!steady && $urandom_range(99) < STALL_PCT) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		kind <= k;
		redraw_all <= redraw;
		top_value <= top;
		bottom_value <= bot;
		cell_row <= row;
		cell_col <= col;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		encode_request(k, redraw, top, bot, row, col);
	endtask

	task automatic send_cell(input logic [23:0] top, input logic [23:0] bot,
			input logic [6:0] row, input logic [7:0] col);
		send_request(KIND_CELL, 1'b0, top, bot, row, col);
	endtask

	// drop push and wait until every expected byte is out, plus a margin for
	// requests that give no bytes but still pass through the pipeline
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (expected_bytes.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_colour_mode(input logic mode);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		truecolor = mode;
	endtask

	// full frame: extreme colours and positions, equal halves, unused kind
	task automatic test_full_frame();
		send_request(KIND_START, 1'b1, '0, '0, '0, '0);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd0);
		send_cell(24'hFFFFFF, 24'h000000, 7'd0, 8'd1);
		send_cell(24'hFFFFFF, 24'h000000, 7'd0, 8'd2);
		send_cell(24'h000000, 24'hFFFFFF, 7'd0, 8'd3);
		send_cell(24'h0A6409, 24'h0A6409, 7'd0, 8'd4);
		send_request(KIND_UNUSED, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 7'd127, 8'd255);
		send_cell(24'h123456, 24'hABCDEF, 7'd127, 8'd254);
		send_cell(24'hFFFFFF, 24'hFFFFFF, 7'd127, 8'd255);
		send_request(KIND_END, 1'b0, '0, '0, '0, '0);
	endtask

	// incremental frame: unchanged cells, a multi-column advance,
	// a skip run dropped at row end, then a cell arriving outside any frame
	task automatic test_incremental_frame();
		send_request(KIND_START, 1'b0, '0, '0, '0, '0);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd0);
		send_cell(24'h00FF00, 24'h000000, 7'd0, 8'd1);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd2);
		send_cell(24'h111111, 24'h222222, 7'd0, 8'd3);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd4);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd5);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd6);
		send_cell(24'h333333, 24'h333333, 7'd0, 8'd7);
		send_cell(24'h000000, 24'h000000, 7'd0, 8'd8);
		send_cell(24'h444444, 24'h555555, 7'd1, 8'd9);
		send_request(KIND_END, 1'b0, '0, '0, '0, '0);
		send_cell(24'h777777, 24'h888888, 7'd2, 8'd0);
	endtask

	// palette form: only the low byte is stored and compared
	task automatic test_palette_mode();
		write_colour_mode(1'b0);
		send_request(KIND_START, 1'b1, '0, '0, '0, '0);
		send_cell(24'hABCDFF, 24'h000000, 7'd3, 8'd0);
		send_cell(24'h1234FF, 24'h777700, 7'd3, 8'd1);
		send_cell(24'h0000FE, 24'h0000FE, 7'd3, 8'd2);
		send_request(KIND_END, 1'b0, '0, '0, '0, '0);
		send_request(KIND_START, 1'b0, '0, '0, '0, '0);
		send_cell(24'hFFFFFF, 24'hFF0000, 7'd3, 8'd0);
		send_cell(24'h55AA07, 24'h000000, 7'd3, 8'd1);
		send_request(KIND_END, 1'b0, '0, '0, '0, '0);
		write_colour_mode(1'b1);
	endtask

	// a run of unchanged cells that overflows the skip counter forces an
	// absolute cursor move at the next changed cell
	task automatic test_skip_overflow();
		send_request(KIND_START, 1'b0, '0, '0, '0, '0);
		send_cell(24'h010203, 24'h040506, 7'd100, 8'd0);
		for (int c = 1; c < 256; c++)
			send_cell(24'h0, 24'h0, 7'd100, 8'(c));
		send_cell(24'h0, 24'h0, 7'd100, 8'd1);
		send_cell(24'h0A0B0C, 24'h0D0E0F, 7'd100, 8'd5);
		send_request(KIND_END, 1'b0, '0, '0, '0, '0);
	endtask

	// random frames over a small window, mostly well-formed raster order;
	// about half the cells repeat what is stored, a few requests are noise
	task automatic test_random_frames(input int n_frames);
		logic [47:0] word;
		logic [23:0] top, bot;
		logic [6:0]  row0;
		int rows, cols, idx;
		for (int f = 0; f < n_frames; f++) begin
			if (f == n_frames / 2) begin
				// hold the sender until the encoder has caught up
				push <= 1'b0;
				do
					@(posedge clk);
				while (expected_bytes.size() != 0);
			end
			steady = (f >= 3 && f < 6);
			rows = $urandom_range(1, 3);
			cols = $urandom_range(2, 8);
			row0 = 7'($urandom_range(0, 127 - rows));
			send_request(KIND_START, 1'($urandom_range(99) < 25), '0, '0, '0, '0);
			for (int r = 0; r < rows; r++)
				for (int c = 0; c < cols; c++) begin
					idx = int'(row0 + r) * COLS + c;
					word = stored_cell(idx);
					case ($urandom_range(9))
						0, 1, 2, 3, 4: begin
							top = word[23:0];
							bot = word[47:24];
						end
						5: begin
							top = 24'($urandom);
							bot = top;
						end
						default: begin
							top = 24'($urandom);
							bot = 24'($urandom);
						end
					endcase
					if ($urandom_range(99) < 4)
						send_request(2'($urandom), 1'($urandom), 24'($urandom),
							24'($urandom), 7'($urandom), 8'($urandom));
					else
						send_cell(top, bot, 7'(row0 + r), 8'(c));
				end
			if ($urandom_range(9) != 0)
				send_request(KIND_END, 1'b0, '0, '0, '0, '0);
		end
		steady = 0;
	endtask

	// ---------------------------------------------------------------- checking

	// pop with random gaps; check each accepted byte against the oldest expectation
	always @(posedge clk) begin
		term_byte_t exp_b;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte %h last %b", out_byte, last);
					errors++;
				end else begin
					exp_b = expected_bytes.pop_front();
					if (out_byte !== exp_b.code) begin
						$error("out_byte expected %h got %h", exp_b.code, out_byte);
						errors++;
					end
					if (last !== exp_b.fin) begin
						$error("last expected %b got %b", exp_b.fin, last);
						errors++;
					end
				end
			end
			// watchdog: advance only while nothing moves on either side
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
		pop <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b1;
		push = 1'b0;
		kind = KIND_CELL;
		redraw_all = 1'b0;
		top_value = '0;
		bottom_value = '0;
		cell_row = '0;
		cell_col = '0;
		errors = 0;
		quiet_cycles = 0;
		steady = 0;
		truecolor = 1'b1;
		term_fg = '0;
		term_bg = '0;
		term_fg_set = 1'b0;
		term_bg_set = 1'b0;
		repaint_all = 1'b1;
		row_open = 1'b0;
		row_now = '0;
		skip_run = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_colour_mode(1'b1);
		test_full_frame();
		test_incremental_frame();
		test_palette_mode();
		test_skip_overflow();
		test_random_frames(6);
		write_colour_mode(1'b0);
		test_random_frames(2);
		write_colour_mode(1'b1);
		test_random_frames(2);

		wait_drained();
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
